// File: hw/rtl/stsr_pkg.sv
// Shared constants, command and status types for the spaced-tap shift register.
package stsr_pkg;

    // Ring and channel geometry
    localparam int RING_DEPTH    = 4096;
    localparam int PTR_W         = $clog2(RING_DEPTH);
    localparam int CHANNEL_COUNT = 16;
    localparam int CHAN_W        = 4;
    localparam int SAMPLE_BITS   = 16;
    localparam int CV_W          = 16;

    // Tap spacing limits
    localparam int SKIP_MAX      = RING_DEPTH / 32 - 1;
    localparam int INCR_MAX      = RING_DEPTH / 32 / CHANNEL_COUNT;
    localparam int SKIP_W        = 8;    // holds SKIP_MAX + 1
    localparam int INCR_W        = 4;    // holds INCR_MAX
    localparam int SKIP_KNOB_W   = 7;
    localparam int INCR_KNOB_W   = 4;

    // Configuration port
    localparam int CFG_W         = 7;
    localparam int CFG_IDX_W     = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_KNOB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCR_KNOB = 2'd1;

    // Voltage scaling: 1 V = 3200 LSB, 10 V = 32000 LSB = 256 * 125
    localparam int ONE_VOLT       = 3200;
    localparam int HALF_TEN_VOLTS = 16000;
    localparam int Y_SHIFT        = 8;       // 32000 = 2^8 * 125
    localparam int Y_W            = 14;
    localparam int RECIP_MUL      = 33555;   // ceil(2^22 / 125), exact below 2^15
    localparam int RECIP_SHIFT    = 22;
    localparam int Q_W            = 8;
    localparam int SUM_W          = 10;

    typedef struct packed {
        logic load;    // take the input word, run the trigger detector
        logic scale;   // ring write, cv products and rounding offset
        logic limit;   // reciprocal multiply
        logic init;    // clamp, seed tap walker
        logic rd;      // read one tap, step the walker
    } t_dp_cmd;

    typedef struct packed {
        logic out_last;  // word held at the output is the final channel
    } t_dp_stat;

endpackage

// File: hw/rtl/stsr_ctrl.sv
// Sequencing state machine for the spaced-tap shift register.
module stsr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stsr_pkg::t_dp_cmd   o_cmd,
    input  stsr_pkg::t_dp_stat  i_stat
);
    import stsr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_LIMIT = 3'd2;
    localparam logic [2:0] ST_INIT  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_SEND  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_take;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_SEND);
    assign w_take      = o_out_valid && i_out_ready;

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.scale = (r_state == ST_SCALE);
        o_cmd.limit = (r_state == ST_LIMIT);
        o_cmd.init  = (r_state == ST_INIT);
        // next tap is read in the same cycle the current word leaves
        o_cmd.rd    = (r_state == ST_READ) || (w_take && !i_stat.out_last);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_SCALE;
            ST_SCALE: n_state = ST_LIMIT;
            ST_LIMIT: n_state = ST_INIT;
            ST_INIT:  n_state = ST_READ;
            ST_READ:  n_state = ST_SEND;
            ST_SEND:  if (w_take && i_stat.out_last) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/stsr_datapath.sv
// Ring memory, trigger detector, spacing arithmetic and tap address walker.
module stsr_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  stsr_pkg::t_dp_cmd                      i_cmd,
    output stsr_pkg::t_dp_stat                     o_stat,
    input  logic signed [stsr_pkg::CV_W-1:0]        i_trigger_level,
    input  logic signed [stsr_pkg::SAMPLE_BITS-1:0] i_source_sample,
    input  logic signed [stsr_pkg::CV_W-1:0]        i_skip_cv,
    input  logic signed [stsr_pkg::CV_W-1:0]        i_increment_cv,
    input  logic                                   i_cfg_we,
    input  logic [stsr_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [stsr_pkg::CFG_W-1:0]              i_cfg_data,
    output logic [stsr_pkg::CHAN_W-1:0]             o_channel,
    output logic signed [stsr_pkg::SAMPLE_BITS-1:0] o_tap_value
);
    import stsr_pkg::*;

    // Ring store; contents are only trusted below the fill mark
    logic [SAMPLE_BITS-1:0] r_ring [RING_DEPTH];

    logic [SKIP_KNOB_W-1:0] r_skip_knob;
    logic [INCR_KNOB_W-1:0] r_incr_knob;
    logic                   r_armed;
    logic [PTR_W-1:0]       r_ptr;
    logic                   r_wrapped;

    logic                   r_fire;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic signed [CV_W-1:0] r_skip_cv;
    logic signed [CV_W-1:0] r_incr_cv;

    logic                   r_skip_neg;
    logic                   r_incr_neg;
    logic [Y_W-1:0]         r_skip_y;
    logic [Y_W-1:0]         r_incr_y;
    logic [Q_W-1:0]         r_skip_q;
    logic [Q_W-1:0]         r_incr_q;

    logic [INCR_W-1:0]      r_incr;
    logic [PTR_W-1:0]       r_span;
    logic [PTR_W-1:0]       r_delta;
    logic [CHAN_W-1:0]      r_rd_chan;
    logic [CHAN_W-1:0]      r_out_chan;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_rd_valid;

    logic                   w_fire;
    logic                   w_disarm;
    logic [PTR_W-1:0]       w_wr_addr;
    logic signed [23:0]     w_skip_n;
    logic signed [23:0]     w_incr_n;
    logic [23:0]            w_skip_mag;
    logic [23:0]            w_incr_mag;
    logic [29:0]            w_skip_pr;
    logic [29:0]            w_incr_pr;
    logic signed [SUM_W-1:0] w_skip_sum;
    logic signed [SUM_W-1:0] w_incr_sum;
    logic [SKIP_W-1:0]      w_skip;
    logic [INCR_W-1:0]      w_incr;
    logic [PTR_W-1:0]       w_rd_addr;

    // Schmitt trigger: fire at 1 V when low, re-arm at 0 V or below
    assign w_fire   = !r_armed && (i_trigger_level >= CV_W'(ONE_VOLT));
    assign w_disarm = r_armed && (i_trigger_level <= $signed(CV_W'(0)));

    assign w_wr_addr = r_ptr + PTR_W'(1);

    // cv * max, then |n| + 5 V, then /256 (the /125 follows by reciprocal)
    assign w_skip_n   = $signed({{8{r_skip_cv[CV_W-1]}}, r_skip_cv}) * $signed(24'(SKIP_MAX));
    assign w_incr_n   = $signed({{8{r_incr_cv[CV_W-1]}}, r_incr_cv}) * $signed(24'(INCR_MAX));
    assign w_skip_mag = w_skip_n[23] ? 24'(-w_skip_n) : 24'(w_skip_n);
    assign w_incr_mag = w_incr_n[23] ? 24'(-w_incr_n) : 24'(w_incr_n);

    assign w_skip_pr = 30'(r_skip_y) * 30'(RECIP_MUL);
    assign w_incr_pr = 30'(r_incr_y) * 30'(RECIP_MUL);

    // knob plus signed rounded cv, then clamp
    assign w_skip_sum = $signed(SUM_W'(r_skip_knob))
                      + (r_skip_neg ? -$signed(SUM_W'(r_skip_q)) : $signed(SUM_W'(r_skip_q)));
    assign w_incr_sum = $signed(SUM_W'(r_incr_knob))
                      + (r_incr_neg ? -$signed(SUM_W'(r_incr_q)) : $signed(SUM_W'(r_incr_q)));

    always_comb begin
        priority if (w_skip_sum < 0) begin
            w_skip = SKIP_W'(1);
        end else if (w_skip_sum > $signed(SUM_W'(SKIP_MAX))) begin
            w_skip = SKIP_W'(SKIP_MAX + 1);
        end else begin
            w_skip = SKIP_W'(w_skip_sum) + SKIP_W'(1);
        end
        priority if (w_incr_sum < 0) begin
            w_incr = '0;
        end else if (w_incr_sum > $signed(SUM_W'(INCR_MAX))) begin
            w_incr = INCR_W'(INCR_MAX);
        end else begin
            w_incr = INCR_W'(w_incr_sum);
        end
    end

    assign w_rd_addr = r_ptr - r_span;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_knob <= '0;
            r_incr_knob <= '0;
            r_armed     <= 1'b0;
            r_ptr       <= '0;
            r_wrapped   <= 1'b0;
            r_fire      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SKIP_KNOB: r_skip_knob <= i_cfg_data[SKIP_KNOB_W-1:0];
                    CFG_INCR_KNOB: r_incr_knob <= i_cfg_data[INCR_KNOB_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_fire <= w_fire;
                if (w_fire) begin
                    r_armed <= 1'b1;
                end else if (w_disarm) begin
                    r_armed <= 1'b0;
                end
            end
            if (i_cmd.scale && r_fire) begin
                r_ptr <= w_wr_addr;
                if (w_wr_addr == '0) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    // Ring write
    always_ff @(posedge i_clk) begin
        if (i_cmd.scale && r_fire) begin
            r_ring[w_wr_addr] <= r_sample;
        end
    end

    // Ring read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_ring[w_rd_addr];
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample  <= i_source_sample;
            r_skip_cv <= i_skip_cv;
            r_incr_cv <= i_increment_cv;
        end
        if (i_cmd.scale) begin
            r_skip_neg <= w_skip_n[23];
            r_incr_neg <= w_incr_n[23];
            r_skip_y   <= Y_W'((w_skip_mag + 24'(HALF_TEN_VOLTS)) >> Y_SHIFT);
            r_incr_y   <= Y_W'((w_incr_mag + 24'(HALF_TEN_VOLTS)) >> Y_SHIFT);
        end
        if (i_cmd.limit) begin
            r_skip_q <= w_skip_pr[RECIP_SHIFT +: Q_W];
            r_incr_q <= w_incr_pr[RECIP_SHIFT +: Q_W];
        end
        if (i_cmd.init) begin
            // span(c) = (skip + incr*c)*c; first difference skip + incr*(2c+1)
            r_incr    <= w_incr;
            r_span    <= '0;
            r_delta   <= PTR_W'(w_skip) + PTR_W'(w_incr);
            r_rd_chan <= '0;
        end else if (i_cmd.rd) begin
            r_span     <= r_span + r_delta;
            r_delta    <= r_delta + PTR_W'({r_incr, 1'b0});
            r_rd_chan  <= r_rd_chan + CHAN_W'(1);
            r_out_chan <= r_rd_chan;
            // slot is filled once the pointer has passed it, or after a wrap
            r_rd_valid <= r_wrapped || ((w_rd_addr != '0) && (w_rd_addr <= r_ptr));
        end
    end

    assign o_channel       = r_out_chan;
    assign o_tap_value     = r_rd_valid ? $signed(r_rd_data) : '0;
    assign o_stat.out_last = (r_out_chan == CHAN_W'(CHANNEL_COUNT - 1));

endmodule

// File: hw/rtl/spaced_tap_shift_register_top.sv
// Top level of the spaced-tap shift register: streaming ports, control and datapath.
//
// Usage
//   Slave channel: one word per sample tick carrying trigger level, source
//   sample and the skip and increment control voltages. A rising trigger
//   (>= 1 V, re-armed at <= 0 V) stores the sample at the next ring slot.
//   Master channel: 16 words per tick, one per channel, channel 0 first.
//   tuser carries the channel index, tlast marks channel 15.
//   Config: i_cfg_we with i_cfg_idx (0 skip knob, 1 increment knob) writes
//   that knob; other indices are ignored. Write only between ticks.
// Timing
//   One tick in flight. Accept, then the setup steps (ring write and cv
//   products, reciprocal multiply, clamp), a ring read, then 16 output
//   words back to back while the receiver is ready. The single-port ring
//   read, one tap per cycle while not stalled, sets the 16-word body.
// Reset
//   Synchronous, active low. Pointer, trigger state and knobs clear. The ring
//   is not swept: a fill mark makes untouched slots read as zero at once.
// Stalls
//   A stalled output word holds; the next tap is read only as a word leaves.
module spaced_tap_shift_register_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: trigger_level[15:0], source_sample[31:16], skip_cv[47:32],
    //        increment_cv[63:48]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // tdata: tap_value[15:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // tuser: channel[3:0]
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [stsr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [stsr_pkg::CFG_W-1:0]     i_cfg_data
);
    import stsr_pkg::*;

    t_dp_cmd                       w_cmd;
    t_dp_stat                      w_stat;
    logic [CHAN_W-1:0]             w_channel;
    logic signed [SAMPLE_BITS-1:0] w_tap_value;

    stsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    stsr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_trigger_level (s_axis_tdata[15:0]),
        .i_source_sample (s_axis_tdata[31:16]),
        .i_skip_cv       (s_axis_tdata[47:32]),
        .i_increment_cv  (s_axis_tdata[63:48]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_channel       (w_channel),
        .o_tap_value     (w_tap_value)
    );

    assign m_axis_tdata = w_tap_value;
    assign m_axis_tuser = w_channel;
    assign m_axis_tlast = w_stat.out_last;

    // One tick at a time: never ready for input while output is pending
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while output pending");

    // Final channel leaves, block is idle again next cycle
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after final channel");

    // Accepted tick closes the input straight after accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened straight after accept");

    // Channels count up one per delivered word within a tick
    a_chan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
            |=> (m_axis_tuser == $past(m_axis_tuser) + 4'd1))
        else $error("channel sequence broken");

endmodule
